// ===== hdl/sspq_pkg.sv =====
// sspq_pkg: shared types and codes for the stable sorted priority queue
// command and response beat structs, command and status codes, cell control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sspq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TAG_W        = 16;
    localparam int TIME_W       = 16;

    localparam logic [2:0] CMD_INS_ORD  = 3'd0;
    localparam logic [2:0] CMD_INS_POS  = 3'd1;
    localparam logic [2:0] CMD_INS_HEAD = 3'd2;
    localparam logic [2:0] CMD_INS_TAIL = 3'd3;
    localparam logic [2:0] CMD_REM_HEAD = 3'd4;
    localparam logic [2:0] CMD_REM_TAG  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]        command;
        logic [TAG_W-1:0]  entry_tag;
        logic [TIME_W-1:0] ready_time;
        logic [7:0]        position;
    } sspq_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TAG_W-1:0]  removed_tag;
        logic [TIME_W-1:0] removed_time;
        logic [4:0]        entry_count;
        logic              is_empty;
        logic [TAG_W-1:0]  head_tag;
        logic [TAG_W-1:0]  tail_tag;
    } sspq_out_t;

    typedef struct packed {
        logic              ins;
        logic              rm;
        logic              ordered;
        logic              by_tag;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] tm;
    } sspq_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/sspq_cell.sv =====
// sspq_cell: one slot of the queue, holding a tag and a ready time
// shifts toward or away from the head as neighbors open or close a slot
// depends on sspq_pkg
`timescale 1ns / 1ps
`default_nettype none

module sspq_cell
    import sspq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX      = 0
)(
    input  wire logic                           clk,
    input  wire sspq_ctl_t                      ctl,
    input  wire logic [$clog2(CAPACITY+1)-1:0]  ins_idx,
    input  wire logic [$clog2(CAPACITY+1)-1:0]  count,
    input  wire logic [TAG_W-1:0]               left_tag,
    input  wire logic [TIME_W-1:0]              left_time,
    input  wire logic [TAG_W-1:0]               right_tag,
    input  wire logic [TIME_W-1:0]              right_time,
    input  wire logic                           ins_before_in,
    input  wire logic                           rm_past_in,
    output logic [TAG_W-1:0]                    tag,
    output logic [TIME_W-1:0]                   tm,
    output logic                                ins_before_out,
    output logic                                rm_past_out,
    output logic [TAG_W-1:0]                    tail_tag
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] MY_LAST = CW'(IDX + 1);

    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic              occ;
    logic              match;

    assign occ   = MY_IDX < count;
    assign match = occ && (tag_reg == ctl.tag);

    assign ins_before_out = ctl.ordered ? (ins_before_in && occ && (time_reg <= ctl.tm))
                                        : (MY_IDX < ins_idx);
    assign rm_past_out    = ctl.by_tag ? (rm_past_in || match) : 1'b1;

    always_comb
    begin
        tag_next  = tag_reg;
        time_next = time_reg;
        if (ctl.ins)
        begin
            if (!ins_before_out)
            begin
                if (ins_before_in)
                begin
                    tag_next  = ctl.tag;
                    time_next = ctl.tm;
                end
                else
                begin
                    tag_next  = left_tag;
                    time_next = left_time;
                end
            end
        end
        else if (ctl.rm && rm_past_out)
        begin
            tag_next  = right_tag;
            time_next = right_time;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        time_reg <= time_next;
    end

    assign tag      = tag_reg;
    assign tm       = time_reg;
    assign tail_tag = (count == MY_LAST) ? tag_reg : '0;

endmodule

`default_nettype wire

// ===== hdl/stable_sorted_priority_queue_core.sv =====
// stable_sorted_priority_queue_core: bounded ordered list of (tag, ready time) entries
// row of sspq_cell slots with a command decode, a result stage and an output register
// depends on sspq_pkg and sspq_cell
//
//   port group   dir   role
//   cmd_*        in    command beat: command, entry_tag, ready_time, position
//   rsp_*        out   response beat: status, removed entry, count, head and tail tags
//
// one command beat per cycle unless stalled; every cell updates in the cycle the beat is taken
// the response is registered in the result stage and then in the output register
// insert position and tag search ripple across the cell row in the accepting cycle
// reset clears the entry count and both valid flags; the slots need no clearing
// a stalled response holds the result stage, which then stalls the command side

`timescale 1ns / 1ps
`default_nettype none

module stable_sorted_priority_queue_core
    import sspq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire sspq_in_t  cmd,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output sspq_out_t      rsp
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam int IW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    typedef struct packed {
        logic [1:0]        status;
        logic [TAG_W-1:0]  rtag;
        logic [TIME_W-1:0] rtime;
    } pend_t;

    logic [CW-1:0]     count_reg, count_next;
    logic              pend_valid_reg, pend_valid_next;
    pend_t             pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    sspq_out_t         out_reg, out_next;

    logic              accept;
    logic              pend_adv;
    logic              is_ins;
    logic              full;
    logic              empty_now;
    logic              found;
    logic [IW-1:0]     pos_m1;
    logic [CW-1:0]     ins_idx;
    sspq_ctl_t         ctl;
    logic [TAG_W-1:0]  tail_any;

    logic [TAG_W-1:0]  cell_tag  [CAPACITY+1];
    logic [TIME_W-1:0] cell_time [CAPACITY+1];
    logic [TAG_W-1:0]  cell_tail [CAPACITY];
    logic              ins_chain [CAPACITY+1];
    logic              rm_chain  [CAPACITY+1];

    assign pend_adv  = pend_valid_reg && (!out_valid_reg || !rsp_stall);
    assign cmd_stall = pend_valid_reg && !pend_adv;
    assign accept    = cmd_valid && !cmd_stall;

    assign is_ins    = cmd.command <= CMD_INS_TAIL;
    assign full      = count_reg == FULL_COUNT;
    assign empty_now = count_reg == '0;
    assign found     = rm_chain[CAPACITY];

    assign pos_m1 = (cmd.position <= 8'd1) ? '0 : (IW'(cmd.position) - IW'(1));

    always_comb
    begin
        unique case (cmd.command)
            CMD_INS_POS:  ins_idx = (pos_m1 > IW'(count_reg)) ? count_reg : CW'(pos_m1);
            CMD_INS_HEAD: ins_idx = '0;
            default:      ins_idx = count_reg;
        endcase
    end

    always_comb
    begin
        ctl.ordered = cmd.command == CMD_INS_ORD;
        ctl.by_tag  = cmd.command == CMD_REM_TAG;
        ctl.tag     = cmd.entry_tag;
        ctl.tm      = cmd.ready_time;
        ctl.ins     = accept && is_ins && !full;
        ctl.rm      = accept && !empty_now
                      && ((cmd.command == CMD_REM_HEAD) || ((cmd.command == CMD_REM_TAG) && found));
    end

    assign ins_chain[0]        = 1'b1;
    assign rm_chain[0]         = 1'b0;
    assign cell_tag[CAPACITY]  = '0;
    assign cell_time[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [TAG_W-1:0]  left_tag;
        logic [TIME_W-1:0] left_time;

        if (g == 0)
        begin : g_first
            assign left_tag  = '0;
            assign left_time = '0;
        end
        else
        begin : g_rest
            assign left_tag  = cell_tag[g-1];
            assign left_time = cell_time[g-1];
        end

        sspq_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .clk            (clk),
            .ctl            (ctl),
            .ins_idx        (ins_idx),
            .count          (count_reg),
            .left_tag       (left_tag),
            .left_time      (left_time),
            .right_tag      (cell_tag[g+1]),
            .right_time     (cell_time[g+1]),
            .ins_before_in  (ins_chain[g]),
            .rm_past_in     (rm_chain[g]),
            .tag            (cell_tag[g]),
            .tm             (cell_time[g]),
            .ins_before_out (ins_chain[g+1]),
            .rm_past_out    (rm_chain[g+1]),
            .tail_tag       (cell_tail[g])
        );
    end

    always_comb
    begin
        tail_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_any = tail_any | cell_tail[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.rm)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
            pend_next.rtag  = '0;
            pend_next.rtime = '0;
            priority if (is_ins)
            begin
                pend_next.status = full ? ST_FULL : ST_OK;
            end
            else if (cmd.command == CMD_REM_HEAD || cmd.command == CMD_REM_TAG)
            begin
                if (empty_now)
                begin
                    pend_next.status = ST_EMPTY;
                end
                else if (cmd.command == CMD_REM_HEAD)
                begin
                    pend_next.status = ST_OK;
                    pend_next.rtag   = cell_tag[0];
                    pend_next.rtime  = cell_time[0];
                end
                else
                begin
                    pend_next.status = found ? ST_OK : ST_NOT_FOUND;
                end
            end
            else
            begin
                pend_next.status = ST_OK;
            end
        end
        else if (pend_adv)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = (out_valid_reg && rsp_stall) || pend_adv;
        if (pend_adv)
        begin
            out_next.status       = pend_reg.status;
            out_next.removed_tag  = pend_reg.rtag;
            out_next.removed_time = pend_reg.rtime;
            out_next.entry_count  = 5'(count_reg);
            out_next.is_empty     = empty_now;
            out_next.head_tag     = empty_now ? '0 : cell_tag[0];
            out_next.tail_tag     = tail_any;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire
